@@ rtl/rbma_pkg.sv @@
// shared types and constants for the ring buffer moving average unit
package rbma_pkg;

    localparam int FILL_W = 6;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUB  = 6'b000010,
        S_ADD  = 6'b000100,
        S_ABS  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

endpackage

@@ rtl/ring_buffer_moving_average_unit.sv @@
// moving average over a ring of the most recent samples, with a shared add/subtract unit
//
// input channel s_axis: tuser carries the operation (push a sample or clear the window),
// tdata carries the signed sample. output channel m_axis: tdata carries the truncated
// average and the fill count, tuser carries the overwrite flag.
// every transfer on s_axis gives exactly one transfer on m_axis.
// a push reads the oldest entry from the sample memory, updates the running sum with two
// passes through the adder, takes the magnitude, then runs a restoring divide of the sum
// by the fill count, one quotient bit per cycle through the same adder, and fixes the sign.
// a push steps from its transfer through S_SUB, S_ADD, S_ABS, the bit-serial divide in S_DIV and
// S_OUT, which writes the result; a clear goes straight to S_OUT. s_axis_tready is high only while
// the sequencer is idle, so no new transfer is taken until the last one has written its result.
// the result sits in an output register: a new item is taken while it waits, and only the
// final step of the next item holds until m_axis_tready frees that register.
// reset empties the window (count, sum and write position go to zero) and drops
// m_axis_tvalid; the sample memory is not cleared, a full window only reads entries
// written since the last clear.
module ring_buffer_moving_average_unit #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // average, fill_count
    output logic [((SAMPLE_BITS + rbma_pkg::FILL_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // overwrote
    output logic m_axis_tuser
);
    import rbma_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int AW     = SUM_W + 1;
    localparam int ITER_W = $clog2(SUM_W);
    localparam int OUT_W  = ((SAMPLE_BITS + FILL_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [POS_W-1:0]       wpos_reg, wpos_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   neg_reg, neg_next;
    logic                   ow_reg, ow_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_avg_reg, out_avg_next;
    logic [FILL_W-1:0]      out_fill_reg, out_fill_next;
    logic                   out_ow_reg, out_ow_next;

    logic                   in_xfer;
    logic                   full;
    logic                   mem_we;
    logic                   out_free;
    logic [CNT_W:0]         rem_shift;
    logic                   div_ge;

    // shared add/subtract unit
    logic [AW-1:0]          alu_a;
    logic [AW-1:0]          alu_b;
    logic                   alu_sub;
    logic [AW-1:0]          alu_res;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign full      = (count_reg == WIN_CNT);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign mem_we    = (state_reg == S_SUB);

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_SUB:
            begin
                alu_a = {sum_reg[SUM_W-1], sum_reg};
                alu_b = {{(AW - SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
            end
            S_ADD:
            begin
                alu_a   = {sum_reg[SUM_W-1], sum_reg};
                alu_b   = {{(AW - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
                alu_sub = 1'b0;
            end
            S_ABS:
            begin
                alu_b = {sum_reg[SUM_W-1], sum_reg};
            end
            S_DIV:
            begin
                alu_a = AW'(rem_shift);
                alu_b = AW'(count_reg);
            end
            S_OUT:
            begin
                alu_b = AW'(quo_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    // both operands are non-negative during the divide, so the top bit is the borrow
    assign div_ge  = !alu_res[AW-1];

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        wpos_next      = wpos_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        neg_next       = neg_reg;
        ow_next        = ow_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_avg_next   = out_avg_reg;
        out_fill_next  = out_fill_reg;
        out_ow_next    = out_ow_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sample_next = s_axis_tdata[SAMPLE_BITS-1:0];
                    ow_next     = 1'b0;
                    if (s_axis_tuser == OP_CLEAR)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        quo_next   = '0;
                        neg_next   = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SUB;
                    end
                end
            end
            S_SUB:
            begin
                // oldest entry leaves the sum when the window is full
                if (full)
                begin
                    sum_next = alu_res[SUM_W-1:0];
                    ow_next  = 1'b1;
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum_next   = alu_res[SUM_W-1:0];
                count_next = full ? count_reg : count_reg + 1'b1;
                wpos_next  = (wpos_reg == LAST_POS) ? '0 : wpos_reg + 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                neg_next   = sum_reg[SUM_W-1];
                quo_next   = sum_reg[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_reg;
                rem_next   = '0;
                iter_next  = ITER_W'(SUM_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = div_ge ? alu_res[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], div_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = neg_reg ? alu_res[SAMPLE_BITS-1:0]
                                             : quo_reg[SAMPLE_BITS-1:0];
                    out_fill_next  = FILL_W'(count_reg);
                    out_ow_next    = ow_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wpos_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        ow_reg       <= ow_next;
        out_avg_reg  <= out_avg_next;
        out_fill_reg <= out_fill_next;
        out_ow_reg   <= out_ow_next;
    end

    // sample memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wpos_reg] <= sample_reg;
        end
        rd_data_reg <= mem[wpos_reg];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_fill_reg, out_avg_reg});
    assign m_axis_tuser  = out_ow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= WIN_CNT)
        else $error("fill count above window size");

    a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= LAST_POS)
        else $error("write position outside the ring");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tuser == OP_CLEAR) |=> (count_reg == '0 && sum_reg == '0))
        else $error("clear did not empty the window");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < count_reg))
        else $error("divider remainder not below divisor");

    a_ow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_fill_reg == FILL_W'(WINDOW)))
        else $error("overwrite reported without a full window");

endmodule
